// File: rtl/core/fhc_pkg.sv
// shared widths, types and register indexes of the fiber hit clusterer
package fhc_pkg;

  localparam int unsigned SegInW = 10;
  localparam int unsigned PosW   = 12;
  localparam int unsigned LayerW = 4;
  localparam int unsigned NumW   = 10;
  localparam int unsigned CntW   = 11;
  localparam int unsigned LxW    = 16;
  localparam int unsigned MeanW  = 16;
  localparam int unsigned SumW   = 22;
  localparam int unsigned OffW   = 8;
  localparam int unsigned FracW  = 4;
  localparam int unsigned DivNW  = SumW + FracW;
  localparam int unsigned DivQW  = 16;
  localparam int unsigned DivCW  = $clog2(DivQW);

  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbAddrLsb = 2;

  localparam logic [ApbAddrW-1:0] RegEvenLzOffset = '0;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [DivNW-1:0] mag;
    logic [CntW-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [MeanW-1:0] quot;
  } div_rsp_t;

endpackage

// File: rtl/core/fhc_if.sv
// hit and cluster channel interfaces
interface fhc_hit_if;
  logic                             valid;
  logic                             ready;
  logic [fhc_pkg::SegInW-1:0]       segment;
  logic signed [fhc_pkg::PosW-1:0]  position_half;
  logic [fhc_pkg::LayerW-1:0]       layer;
  logic                             last_in_layer;

  modport source (output valid, segment, position_half, layer, last_in_layer, input ready);
  modport sink (input valid, segment, position_half, layer, last_in_layer, output ready);
endinterface

interface fhc_clu_if;
  logic                              valid;
  logic                              ready;
  logic [fhc_pkg::NumW-1:0]          cluster_number;
  logic [fhc_pkg::CntW-1:0]          hit_count;
  logic [fhc_pkg::CntW-1:0]          lz_size;
  logic signed [fhc_pkg::LxW-1:0]    lx_size_sixteenths;
  logic signed [fhc_pkg::MeanW-1:0]  mean_position;
  logic [fhc_pkg::LayerW-1:0]        cluster_layer;
  logic                              last_of_run;

  modport source (output valid, cluster_number, hit_count, lz_size, lx_size_sixteenths,
                  mean_position, cluster_layer, last_of_run, input ready);
  modport sink (input valid, cluster_number, hit_count, lz_size, lx_size_sixteenths,
                mean_position, cluster_layer, last_of_run, output ready);
endinterface

// File: rtl/core/fiber_hit_clusterer.sv
// fiber hit clusterer top level: cluster tracking, sequencer and output word
// Hits of one layer enter one word at a time in ascending segment order. A hit
// that continues the open cluster (segment one or two above the previous) passes
// through the eval and last states before the next word can be accepted. Every
// cluster word that a hit produces adds a divider run plus the wait for the sink:
// the mean position is formed by one shared radix-2 divider that yields one
// quotient bit per cycle. A hit that closes a cluster and is also the last of its
// layer produces two cluster words, one after the other. The even lz offset
// register should be written only while no hit is in flight.
module fiber_hit_clusterer #(
  parameter int unsigned SEGMENT_COUNT = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fhc_pkg::ApbAddrW-1:0]      paddr,
  input  logic [fhc_pkg::ApbDataW-1:0]      pwdata,
  output logic [fhc_pkg::ApbDataW-1:0]      prdata,
  output logic                              pready,
  fhc_hit_if.sink                           hit_i,
  fhc_clu_if.source                         clu_o
);

  localparam int unsigned SegW = ($clog2(SEGMENT_COUNT) < fhc_pkg::SegInW) ?
                                 $clog2(SEGMENT_COUNT) : fhc_pkg::SegInW;
  localparam logic [16:0] SegMax = 17'(SEGMENT_COUNT - 1);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StEval = 3'd1;
  localparam logic [2:0] StLast = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0] state_q, state_d;

  logic signed [fhc_pkg::OffW-1:0] even_lz_offset;
  fhc_pkg::div_req_t               div_req;
  fhc_pkg::div_rsp_t               div_rsp;

  // latched hit
  logic [SegW-1:0]                   seg_q;
  logic signed [fhc_pkg::PosW-1:0]   pos_q;
  logic [fhc_pkg::LayerW-1:0]        layer_q;
  logic                              last_q;

  // open cluster
  logic                              open_q;
  logic [SegW-1:0]                   prev_q;
  logic [SegW-1:0]                   prev2_q;
  logic                              prev2_vld_q;
  logic [fhc_pkg::CntW-1:0]          cnt_q;
  logic [fhc_pkg::CntW-1:0]          lz_q;
  logic [fhc_pkg::CntW-1:0]          lx_q;
  logic signed [fhc_pkg::SumW-1:0]   sum_q;
  logic [fhc_pkg::NumW-1:0]          num_q;

  logic                              lol_q;
  logic                              clear_pend_q;

  // output word
  logic [fhc_pkg::NumW-1:0]          o_num_q;
  logic [fhc_pkg::CntW-1:0]          o_cnt_q;
  logic [fhc_pkg::CntW-1:0]          o_lz_q;
  logic signed [fhc_pkg::LxW-1:0]    o_lx_q;
  logic signed [fhc_pkg::MeanW-1:0]  o_mean_q;
  logic [fhc_pkg::LayerW-1:0]        o_layer_q;
  logic                              o_last_q;

  logic [SegW-1:0]                   seg_sat;
  logic                              step1;
  logic                              step2;
  logic                              skip2;
  logic                              emit_eval;
  logic                              emit_last;
  logic [fhc_pkg::SumW-1:0]          sum_mag;
  logic signed [fhc_pkg::LxW-1:0]    lx_base;

  fhc_cfg u_cfg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .even_lz_offset_o (even_lz_offset)
  );

  fhc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign seg_sat = (17'(hit_i.segment) > SegMax) ? SegMax[SegW-1:0] :
                   hit_i.segment[SegW-1:0];

  assign step1 = {1'b0, seg_q} == ({1'b0, prev_q} + (SegW+1)'(1));
  assign step2 = {1'b0, seg_q} == ({1'b0, prev_q} + (SegW+1)'(2));
  assign skip2 = prev2_vld_q && ({1'b0, seg_q} == ({1'b0, prev2_q} + (SegW+1)'(2)));

  assign emit_eval = (state_q == StEval) && open_q && !step1 && !step2;
  assign emit_last = (state_q == StLast) && last_q;

  assign sum_mag = sum_q[fhc_pkg::SumW-1] ? fhc_pkg::SumW'(-sum_q) : fhc_pkg::SumW'(sum_q);

  always_comb begin
    div_req.start = emit_eval || emit_last;
    div_req.neg   = sum_q[fhc_pkg::SumW-1];
    div_req.mag   = {sum_mag, {fhc_pkg::FracW{1'b0}}};
    div_req.den   = cnt_q;
  end

  assign lx_base = $signed({1'b0, lx_q, {fhc_pkg::FracW{1'b0}}});

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (hit_i.valid) state_d = StEval;
      end
      StEval: begin
        state_d = emit_eval ? StDiv : StLast;
      end
      StLast: begin
        state_d = last_q ? StDiv : StIdle;
      end
      StDiv: begin
        if (div_rsp.done) state_d = StOut;
      end
      StOut: begin
        if (clu_o.ready) state_d = clear_pend_q ? StIdle : StLast;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      open_q       <= 1'b0;
      prev_q       <= '0;
      prev2_q      <= '0;
      prev2_vld_q  <= 1'b0;
      cnt_q        <= '0;
      lz_q         <= fhc_pkg::CntW'(1);
      lx_q         <= fhc_pkg::CntW'(1);
      sum_q        <= '0;
      num_q        <= '0;
      lol_q        <= 1'b0;
      clear_pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StEval) begin
        if (!open_q) begin
          open_q      <= 1'b1;
          prev_q      <= seg_q;
          prev2_vld_q <= 1'b0;
          cnt_q       <= fhc_pkg::CntW'(1);
          lz_q        <= fhc_pkg::CntW'(1);
          lx_q        <= fhc_pkg::CntW'(1);
          sum_q       <= fhc_pkg::SumW'(pos_q);
        end else if (step1 || step2) begin
          if (step1) lz_q <= lz_q + 1'b1;
          if (step2 || skip2) lx_q <= lx_q + 1'b1;
          prev2_q     <= prev_q;
          prev2_vld_q <= 1'b1;
          prev_q      <= seg_q;
          cnt_q       <= cnt_q + 1'b1;
          sum_q       <= sum_q + fhc_pkg::SumW'(pos_q);
        end else begin
          lol_q        <= !last_q;
          clear_pend_q <= 1'b0;
        end
      end
      if (emit_last) begin
        lol_q        <= 1'b1;
        clear_pend_q <= 1'b1;
      end
      if ((state_q == StDiv) && div_rsp.done) begin
        num_q <= num_q + 1'b1;
      end
      if ((state_q == StOut) && clu_o.ready) begin
        if (clear_pend_q) begin
          open_q      <= 1'b0;
          prev_q      <= '0;
          prev2_vld_q <= 1'b0;
          cnt_q       <= '0;
          lz_q        <= fhc_pkg::CntW'(1);
          lx_q        <= fhc_pkg::CntW'(1);
          sum_q       <= '0;
          num_q       <= '0;
        end else begin
          open_q      <= 1'b1;
          prev_q      <= seg_q;
          prev2_vld_q <= 1'b0;
          cnt_q       <= fhc_pkg::CntW'(1);
          lz_q        <= fhc_pkg::CntW'(1);
          lx_q        <= fhc_pkg::CntW'(1);
          sum_q       <= fhc_pkg::SumW'(pos_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == StIdle) && hit_i.valid) begin
      seg_q   <= seg_sat;
      pos_q   <= hit_i.position_half;
      layer_q <= hit_i.layer;
      last_q  <= hit_i.last_in_layer;
    end
    if ((state_q == StDiv) && div_rsp.done) begin
      o_num_q   <= num_q;
      o_cnt_q   <= cnt_q;
      o_lz_q    <= lz_q;
      o_lx_q    <= lz_q[0] ? lx_base : lx_base + fhc_pkg::LxW'(even_lz_offset);
      o_mean_q  <= div_rsp.quot;
      o_layer_q <= layer_q;
      o_last_q  <= lol_q;
    end
  end

  assign hit_i.ready = (state_q == StIdle);

  assign clu_o.valid              = (state_q == StOut);
  assign clu_o.cluster_number     = o_num_q;
  assign clu_o.hit_count          = o_cnt_q;
  assign clu_o.lz_size            = o_lz_q;
  assign clu_o.lx_size_sixteenths = o_lx_q;
  assign clu_o.mean_position      = o_mean_q;
  assign clu_o.cluster_layer      = o_layer_q;
  assign clu_o.last_of_run        = o_last_q;

endmodule

// File: rtl/core/fhc_cfg.sv
// apb register block holding the even lz offset
module fhc_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [fhc_pkg::ApbAddrW-1:0]         paddr,
  input  logic [fhc_pkg::ApbDataW-1:0]         pwdata,
  output logic [fhc_pkg::ApbDataW-1:0]         prdata,
  output logic                                 pready,
  output logic signed [fhc_pkg::OffW-1:0]      even_lz_offset_o
);

  logic                            sel_off;
  logic signed [fhc_pkg::OffW-1:0] off_q;

  assign sel_off = (paddr >> fhc_pkg::ApbAddrLsb) == fhc_pkg::RegEvenLzOffset;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
    end else if (psel && penable && pwrite && sel_off) begin
      off_q <= pwdata[fhc_pkg::OffW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_off) begin
      prdata = fhc_pkg::ApbDataW'(off_q);
    end
  end

  assign even_lz_offset_o = off_q;

endmodule

// File: rtl/core/fhc_div.sv
// shared radix-2 restoring divider for the cluster mean, one quotient bit per cycle
module fhc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fhc_pkg::div_req_t req_i,
  output fhc_pkg::div_rsp_t rsp_o
);

  logic [fhc_pkg::CntW-1:0]  rem_q;
  logic [fhc_pkg::DivQW-1:0] quo_q;
  logic [fhc_pkg::CntW-1:0]  den_q;
  logic                      neg_q;
  logic [fhc_pkg::DivCW-1:0] cnt_q;
  logic                      busy_q;
  logic                      done_q;

  logic [fhc_pkg::CntW:0]    trial;
  logic                      ge;
  logic [fhc_pkg::CntW-1:0]  rem_d;

  assign trial = {rem_q, quo_q[fhc_pkg::DivQW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign rem_d = ge ? fhc_pkg::CntW'(trial - {1'b0, den_q}) : trial[fhc_pkg::CntW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == fhc_pkg::DivCW'(fhc_pkg::DivQW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // upper dividend bits are always below the divisor, so 16 steps suffice
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= fhc_pkg::CntW'(req_i.mag[fhc_pkg::DivNW-1:fhc_pkg::DivQW]);
      quo_q <= req_i.mag[fhc_pkg::DivQW-1:0];
      den_q <= req_i.den;
      neg_q <= req_i.neg;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[fhc_pkg::DivQW-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = neg_q ? fhc_pkg::MeanW'(-quo_q) : fhc_pkg::MeanW'(quo_q);

endmodule
